// ----- design/truncated_gaussian_density_macros.svh -----
// ---------------------------------------------------------------------------
// Truncated Gaussian density: assertion macros
// Shared property forms used by the checker that watches the top level.
// ---------------------------------------------------------------------------
`ifndef TRUNCATED_GAUSSIAN_DENSITY_MACROS_SVH
`define TRUNCATED_GAUSSIAN_DENSITY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TGD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("truncated_gaussian_density: implication violated");

// Implication after a fixed number of cycles, disabled during reset.
`define TGD_ASSERT_DLY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("truncated_gaussian_density: delayed implication violated");

`endif

// ----- design/tgd_pkg.sv -----
// ---------------------------------------------------------------------------
// Truncated Gaussian density: package
// Shared types, register indexes, pipeline depths and the exp(-n) table.
// ---------------------------------------------------------------------------
`default_nettype none

package tgd_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Register indexes of the configuration channel.
  localparam logic [1:0] REG_MEAN  = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_LOW   = 2'd2;
  localparam logic [1:0] REG_HIGH  = 2'd3;

  localparam int FRONT_STAGES = 3;
  localparam int INT_STEPS    = 5;
  localparam int FRAC_STEPS   = 31;
  localparam int DIV_STAGES   = INT_STEPS + FRAC_STEPS;
  localparam int SERIES_TERMS = 16;
  localparam int EXP_STAGES   = 3 * SERIES_TERMS;
  localparam int BACK_STAGES  = 3;
  localparam int TGD_LATENCY  = FRONT_STAGES + DIV_STAGES + EXP_STAGES + BACK_STAGES;

  localparam int MAX_INT = 16;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [30:0]        width;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } tgd_cfg_t;

  typedef struct packed {
    logic valid;
    logic outside;
    logic zero;
  } tgd_ctl_t;

  // exp(-n) in Q1.31 for n = 0..16, built from a truncated series for exp(-1).
  function automatic logic [32*(MAX_INT+1)-1:0] tgd_en_table();
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e1;
    logic [63:0] en;
    logic [32*(MAX_INT+1)-1:0] tab;
    term = 64'd1 << 31;
    pos  = 64'd1 << 31;
    neg  = 64'd0;
    for (int k = 1; k <= 20; k++) begin
      term = term / 64'(k);
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    e1  = pos - neg;
    en  = 64'd1 << 31;
    tab = '0;
    for (int i = 0; i <= MAX_INT; i++) begin
      tab[32*i +: 32] = en[31:0];
      en = (en * e1) >> 31;
    end
    return tab;
  endfunction

  localparam logic [32*(MAX_INT+1)-1:0] TGD_EN_TAB = tgd_en_table();

endpackage

`default_nettype wire

// ----- design/tgd_front.sv -----
// ---------------------------------------------------------------------------
// Truncated Gaussian density: front end
// Window check, offset from the centre, and the squares that feed the divider.
// ---------------------------------------------------------------------------
`default_nettype none

module tgd_front
  import tgd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] sample,
  input  wire tgd_cfg_t           cfg,
  output tgd_ctl_t                ctl,
  output logic [63:0]             d2,
  output logic [62:0]             den
);

  tgd_ctl_t           s1_ctl;
  tgd_ctl_t           s2_ctl;
  logic signed [32:0] s1_diff;
  logic [30:0]        s1_sig;
  logic [31:0]        s2_abs;
  logic [61:0]        s2_sigsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      ctl    <= '0;
    end else begin
      s1_ctl.valid   <= in_valid;
      s1_ctl.outside <= (sample < cfg.lo) || (sample > cfg.hi);
      s1_ctl.zero    <= 1'b0;
      s2_ctl         <= s1_ctl;
      ctl            <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s1_diff  <= 33'(sample) - 33'(cfg.mean);
    s1_sig   <= (cfg.width == '0) ? 31'd1 : cfg.width;
    s2_abs   <= s1_diff[32] ? 32'(-s1_diff) : s1_diff[31:0];
    s2_sigsq <= 62'(s1_sig) * 62'(s1_sig);
    d2       <= 64'(s2_abs) * 64'(s2_abs);
    den      <= {s2_sigsq, 1'b0};
  end

endmodule

`default_nettype wire

// ----- design/tgd_divider.sv -----
// ---------------------------------------------------------------------------
// Truncated Gaussian density: divider
// Restoring division of d*d by 2*sigma*sigma, one quotient bit per stage:
// five integer bits, then a 31-bit fraction.
// ---------------------------------------------------------------------------
`default_nettype none

module tgd_divider
  import tgd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire tgd_ctl_t    in_ctl,
  input  wire logic [63:0] d2,
  input  wire logic [62:0] den,
  output tgd_ctl_t         ctl,
  output logic [4:0]       n,
  output logic [30:0]      frac
);

  logic [63:0] rem_a  [0:DIV_STAGES];
  logic [62:0] den_a  [0:DIV_STAGES];
  logic [4:0]  n_a    [0:DIV_STAGES];
  logic [30:0] frac_a [0:DIV_STAGES];
  tgd_ctl_t    ctl_a  [0:DIV_STAGES];

  assign rem_a[0]  = d2;
  assign den_a[0]  = den;
  assign n_a[0]    = '0;
  assign frac_a[0] = '0;
  assign ctl_a[0]  = in_ctl;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
    logic        ge;
    logic [63:0] rem_new;
    logic [4:0]  n_new;
    logic        zero_new;

    if (j < INT_STEPS) begin : g_int
      localparam int B = INT_STEPS - 1 - j;
      logic [67:0] dsh;
      always_comb begin
        dsh     = 68'(den_a[j]) << B;
        ge      = 68'(rem_a[j]) >= dsh;
        rem_new = ge ? 64'(68'(rem_a[j]) - dsh) : rem_a[j];
        n_new   = n_a[j] | (5'(ge) << B);
      end
    end else begin : g_frac
      logic [64:0] rs;
      always_comb begin
        rs      = {rem_a[j], 1'b0};
        ge      = rs >= 65'(den_a[j]);
        rem_new = ge ? 64'(rs - 65'(den_a[j])) : rs[63:0];
        n_new   = n_a[j];
      end
    end

    // Once the integer part is known, mark samples beyond q/2 = 16.
    if (j == INT_STEPS - 1) begin : g_chk
      assign zero_new = ctl_a[j].zero || (n_new > 5'(MAX_INT)) ||
                        ((n_new == 5'(MAX_INT)) && (rem_new != '0));
    end else begin : g_pass
      assign zero_new = ctl_a[j].zero;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_a[j+1] <= '0;
      end else begin
        ctl_a[j+1]      <= ctl_a[j];
        ctl_a[j+1].zero <= zero_new;
      end
    end

    always_ff @(posedge clk) begin
      rem_a[j+1] <= rem_new;
      den_a[j+1] <= den_a[j];
      n_a[j+1]   <= n_new;
      if (j < INT_STEPS) frac_a[j+1] <= frac_a[j];
      else frac_a[j+1] <= {frac_a[j][29:0], ge};
    end
  end

  assign ctl  = ctl_a[DIV_STAGES];
  assign n    = n_a[DIV_STAGES];
  assign frac = frac_a[DIV_STAGES];

endmodule

`default_nettype wire

// ----- design/tgd_exp_series.sv -----
// ---------------------------------------------------------------------------
// Truncated Gaussian density: fractional exponential
// exp(-f) for f in [0,1) by a 16-term series, three stages per term:
// multiply by f, multiply by the reciprocal of k, then correct and add.
// ---------------------------------------------------------------------------
`default_nettype none

module tgd_exp_series
  import tgd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire tgd_ctl_t    in_ctl,
  input  wire logic [4:0]  in_n,
  input  wire logic [30:0] frac,
  output tgd_ctl_t         ctl,
  output logic [4:0]       n,
  output logic [31:0]      ef
);

  logic [31:0] term_a [0:EXP_STAGES];
  logic [31:0] p_a    [0:EXP_STAGES];
  logic [64:0] prod_a [0:EXP_STAGES];
  logic [33:0] pos_a  [0:EXP_STAGES];
  logic [33:0] neg_a  [0:EXP_STAGES];
  logic [30:0] f_a    [0:EXP_STAGES];
  logic [4:0]  n_a    [0:EXP_STAGES];
  tgd_ctl_t    ctl_a  [0:EXP_STAGES];

  assign term_a[0] = 32'd1 << 31;
  assign p_a[0]    = '0;
  assign prod_a[0] = '0;
  assign pos_a[0]  = 34'd1 << 31;
  assign neg_a[0]  = '0;
  assign f_a[0]    = frac;
  assign n_a[0]    = in_n;
  assign ctl_a[0]  = in_ctl;

  for (genvar s = 0; s < EXP_STAGES; s++) begin : g_stage
    localparam int K    = s / 3 + 1;
    localparam int KIND = s % 3;
    localparam logic [32:0] RECIP = 33'((65'd1 << 32) / K);

    logic [31:0] term_new;
    logic [31:0] p_new;
    logic [64:0] prod_new;
    logic [33:0] pos_new;
    logic [33:0] neg_new;

    if (KIND == 0) begin : g_mul_f
      logic [62:0] tf;
      always_comb begin
        tf       = 63'(term_a[s]) * 63'(f_a[s]);
        p_new    = tf[62:31];
        term_new = term_a[s];
        prod_new = prod_a[s];
        pos_new  = pos_a[s];
        neg_new  = neg_a[s];
      end
    end else if (KIND == 1) begin : g_mul_r
      always_comb begin
        p_new    = p_a[s];
        prod_new = 65'(p_a[s]) * 65'(RECIP);
        term_new = term_a[s];
        pos_new  = pos_a[s];
        neg_new  = neg_a[s];
      end
    end else begin : g_fix
      // The reciprocal estimate is exact or one short; one compare settles it.
      logic [31:0] q0;
      logic [35:0] r;
      always_comb begin
        q0       = prod_a[s][63:32];
        r        = 36'(p_a[s]) - 36'(q0) * 36'(K);
        term_new = (r >= 36'(K)) ? q0 + 32'd1 : q0;
        p_new    = p_a[s];
        prod_new = prod_a[s];
        if (K % 2 == 1) begin
          pos_new = pos_a[s];
          neg_new = neg_a[s] + 34'(term_new);
        end else begin
          pos_new = pos_a[s] + 34'(term_new);
          neg_new = neg_a[s];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_a[s+1] <= '0;
      end else begin
        ctl_a[s+1] <= ctl_a[s];
      end
    end

    always_ff @(posedge clk) begin
      term_a[s+1] <= term_new;
      p_a[s+1]    <= p_new;
      prod_a[s+1] <= prod_new;
      pos_a[s+1]  <= pos_new;
      neg_a[s+1]  <= neg_new;
      f_a[s+1]    <= f_a[s];
      n_a[s+1]    <= n_a[s];
    end
  end

  assign ctl = ctl_a[EXP_STAGES];
  assign n   = n_a[EXP_STAGES];
  assign ef  = 32'(pos_a[EXP_STAGES] - neg_a[EXP_STAGES]);

endmodule

`default_nettype wire

// ----- design/truncated_gaussian_density.sv -----
// ---------------------------------------------------------------------------
// Truncated Gaussian density evaluator
// Returns round(2^FRAC_BITS * exp(-(x-mean)^2 / (2 sigma^2))) inside a window.
// ---------------------------------------------------------------------------
// Usage:
//   A sample word is taken at a clock edge where start is high and busy is
//   low. Its result appears on density and outside, marked by done, for one
//   cycle after 3 front-end stages, 36 divider stages, 48 series stages and
//   3 output stages. A new sample may be given in every cycle while busy is
//   low, so throughput is one word per cycle.
//   Samples below window_low or above window_high give outside = 1 and
//   density 0; beyond q/2 = 16 the density is 0.
//   Registers are written over the cfg channel (cfg_valid, cfg_ready,
//   cfg_index, cfg_data) and must only change while no sample is in flight.
//   Synchronous reset empties the pipeline and loads the register defaults:
//   mean 0, width 1.0, widest window; busy stays high during reset and in the
//   cycle after it. The receiver cannot stall: done lasts a single cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module truncated_gaussian_density
  import tgd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] sample,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    done,
  output logic [FRAC_BITS:0]      density,
  output logic                    outside
);

  localparam int RSH = 31 - FRAC_BITS;

  tgd_cfg_t    cfg;
  logic        init_hold;
  tgd_ctl_t    fr_ctl;
  logic [63:0] fr_d2;
  logic [62:0] fr_den;
  tgd_ctl_t    dv_ctl;
  logic [4:0]  dv_n;
  logic [30:0] dv_frac;
  tgd_ctl_t    ex_ctl;
  logic [4:0]  ex_n;
  logic [31:0] ex_ef;
  tgd_ctl_t    t1_ctl;
  tgd_ctl_t    t2_ctl;
  logic [31:0] t1_en;
  logic [31:0] t1_ef;
  logic [31:0] t2_val;
  logic [63:0] prod;
  logic [32:0] rsum;

  assign busy      = rst || init_hold;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_hold <= 1'b1;
      cfg.mean  <= '0;
      cfg.width <= 31'd1 << FRAC_BITS;
      cfg.lo    <= 32'sh8000_0000;
      cfg.hi    <= 32'sh7fff_ffff;
    end else begin
      init_hold <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MEAN:  cfg.mean  <= cfg_data;
          REG_WIDTH: cfg.width <= cfg_data[30:0];
          REG_LOW:   cfg.lo    <= cfg_data;
          REG_HIGH:  cfg.hi    <= cfg_data;
          default:   cfg.mean  <= cfg.mean;
        endcase
      end
    end
  end

  tgd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .sample   (sample),
    .cfg      (cfg),
    .ctl      (fr_ctl),
    .d2       (fr_d2),
    .den      (fr_den)
  );

  tgd_divider u_divider (
    .clk    (clk),
    .rst    (rst),
    .in_ctl (fr_ctl),
    .d2     (fr_d2),
    .den    (fr_den),
    .ctl    (dv_ctl),
    .n      (dv_n),
    .frac   (dv_frac)
  );

  tgd_exp_series u_exp (
    .clk    (clk),
    .rst    (rst),
    .in_ctl (dv_ctl),
    .in_n   (dv_n),
    .frac   (dv_frac),
    .ctl    (ex_ctl),
    .n      (ex_n),
    .ef     (ex_ef)
  );

  assign prod = 64'(t1_en) * 64'(t1_ef);
  assign rsum = 33'(t2_val) + (33'd1 << (RSH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_ctl <= '0;
      t2_ctl <= '0;
      done   <= 1'b0;
    end else begin
      t1_ctl <= ex_ctl;
      t2_ctl <= t1_ctl;
      done   <= t2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    t1_en   <= (ex_n > 5'(MAX_INT)) ? 32'd0 : TGD_EN_TAB[32*ex_n +: 32];
    t1_ef   <= ex_ef;
    t2_val  <= prod[62:31];
    outside <= t2_ctl.outside;
    density <= (t2_ctl.outside || t2_ctl.zero) ? '0 : rsum[RSH +: FRAC_BITS+1];
  end

endmodule

`default_nettype wire

// ----- design/tgd_checker.sv -----
// ---------------------------------------------------------------------------
// Truncated Gaussian density: port checker
// Watches the top-level ports for latency, result range and the window flag.
// ---------------------------------------------------------------------------
`default_nettype none

`include "truncated_gaussian_density_macros.svh"

module tgd_checker
  import tgd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire logic [FRAC_BITS:0] density,
  input wire logic               outside
);

  logic accepted;
  assign accepted = start && !busy;

  // Every accepted word produces exactly one result after the fixed latency.
  `TGD_ASSERT_DLY(a_latency, accepted, TGD_LATENCY, done)
  `TGD_ASSERT_IMP(a_no_spurious, done, $past(accepted, TGD_LATENCY))
  // A sample outside the window never carries a density.
  `TGD_ASSERT_IMP(a_outside_zero, done && outside, density == '0)
  // The density never exceeds 1.0.
  `TGD_ASSERT_IMP(a_range, done, density <= ((FRAC_BITS+1)'(1) << FRAC_BITS))

endmodule

bind truncated_gaussian_density tgd_checker #(.FRAC_BITS(FRAC_BITS)) u_tgd_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .density (density),
  .outside (outside)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// Truncated Gaussian density: testbench
// Drives sample words at up to one per cycle, in most phases with random gaps,
// across a set of mean, width and window settings. Every result is compared
// with a bit-exact Gaussian density predictor or a typed-in table value. A
// short table of directed samples runs first.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tgd_pkg::*;

  localparam int LIMIT = 5000;
  localparam int ITEMS_PER_SETTING = 172;

  typedef struct packed {
    logic [16:0] density;
    logic        outside;
  } dens_res_t;

  typedef struct {
    logic signed [31:0] sample;
    bit                 known;
    logic [16:0]        density;
    logic               outside;
  } dir_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [31:0] sample;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic done;
  logic [16:0] density;
  logic outside;

  // Predictor copy of the registers.
  logic signed [31:0] p_mean;
  logic [30:0]        p_width;
  logic signed [31:0] p_low;
  logic signed [31:0] p_high;

  dens_res_t pending_q[$];
  dens_res_t known_q[$];
  bit        known_flag_q[$];
  int        fails;
  int        quiet_cycles;
  bit        gaps_on;
  bit        cur_known;
  dens_res_t cur_expect;

  truncated_gaussian_density dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .density(density), .outside(outside)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] exp_neg_one_q31();
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 31;
    pos  = term;
    neg  = 64'd0;
    for (int k = 1; k <= 20; k++) begin
      term = term / 64'(k);
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    return pos - neg;
  endfunction

  function automatic logic [63:0] exp_neg_frac_q31(logic [63:0] f);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 31;
    pos  = term;
    neg  = 64'd0;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * f) >> 31) / 64'(k);
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    return pos - neg;
  endfunction

  function automatic dens_res_t gauss_density(logic signed [31:0] x);
    dens_res_t r;
    logic signed [63:0] d;
    logic [63:0] ad;
    logic [63:0] d2;
    logic [63:0] sig;
    logic [63:0] den;
    logic [63:0] n;
    logic [63:0] rem;
    logic [63:0] frac;
    logic [63:0] en;
    logic [63:0] e1;
    logic [63:0] val;
    r = '0;
    if (x < p_low || x > p_high) begin
      r.outside = 1'b1;
      return r;
    end
    d   = 64'(x) - 64'(p_mean);
    ad  = d < 0 ? 64'(-d) : 64'(d);
    d2  = ad * ad;
    sig = (p_width == 0) ? 64'd1 : 64'(p_width);
    den = 64'd2 * sig * sig;
    n   = d2 / den;
    rem = d2 % den;
    if (n > 64'd16 || (n == 64'd16 && rem != 0)) return r;
    frac = 64'd0;
    for (int i = 0; i < 31; i++) begin
      rem  = rem << 1;
      frac = frac << 1;
      if (rem >= den) begin
        rem  = rem - den;
        frac = frac | 64'd1;
      end
    end
    e1 = exp_neg_one_q31();
    en = 64'd1 << 31;
    for (int i = 0; i < int'(n); i++) en = (en * e1) >> 31;
    val = (en * exp_neg_frac_q31(frac)) >> 31;
    r.density = 17'((val + (64'd1 << 14)) >> 15);
    return r;
  endfunction

  // Accepted words, register writes and results, all seen at the rising edge.
  always @(posedge clk) begin
    dens_res_t exp_r;
    dens_res_t tab_r;
    bit        has_tab;
    bit        moved;
    moved = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        pending_q.push_back(gauss_density(sample));
        known_q.push_back(cur_expect);
        known_flag_q.push_back(cur_known);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MEAN:  p_mean  <= cfg_data;
          REG_WIDTH: p_width <= cfg_data[30:0];
          REG_LOW:   p_low   <= cfg_data;
          REG_HIGH:  p_high  <= cfg_data;
          default: ;
        endcase
        moved = 1'b1;
      end
      if (done) begin
        moved = 1'b1;
        if (pending_q.size() == 0) begin
          $error("result word with none expected: density %0d outside %0b",
                 density, outside);
          fails++;
        end else begin
          exp_r   = pending_q.pop_front();
          tab_r   = known_q.pop_front();
          has_tab = known_flag_q.pop_front();
          // A typed-in value in the table overrides the predictor.
          if (has_tab) exp_r = tab_r;
          if (density !== exp_r.density) begin
            $error("density: expected %0d, got %0d", exp_r.density, density);
            fails++;
          end
          if (outside !== exp_r.outside) begin
            $error("outside: expected %0b, got %0b", exp_r.outside, outside);
            fails++;
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(logic signed [31:0] s, bit known, dens_res_t expect_r);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    sample     <= s;
    cur_known  <= known;
    cur_expect <= expect_r;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (TGD_LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setting(logic signed [31:0] m, logic [30:0] w,
                              logic signed [31:0] lo, logic signed [31:0] hi);
    write_reg(REG_MEAN, m);
    write_reg(REG_WIDTH, {1'b0, w});
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Mostly samples within a few widths of the centre, some on or just beyond
  // the window edges, the rest anywhere.
  task automatic random_words(int count);
    longint span;
    longint off;
    logic signed [31:0] s;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        span = longint'(p_width == 0 ? 1 : p_width) * 6;
        off  = longint'({$urandom, $urandom}) % (span + 1);
        if ($urandom_range(0, 1)) off = -off;
        s = clamp32(longint'(p_mean) + off);
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0: s = p_low;
          1: s = p_high;
          2: s = clamp32(longint'(p_low) - 1);
          default: s = clamp32(longint'(p_high) + 1);
        endcase
      end else begin
        s = $urandom;
      end
      send_word(s, 1'b0, '0);
    end
  endtask

  dir_row_t dir_rows[$];

  initial begin
    logic signed [31:0] m;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [30:0] w;
    rst = 1'b1;
    start = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MEAN;
    cfg_data = '0;
    fails = 0;
    quiet_cycles = 0;
    gaps_on = 1'b0;
    cur_known = 1'b0;
    cur_expect = '0;
    p_mean = 32'sd0;
    p_width = 31'd65536;
    p_low = 32'sh80000000;
    p_high = 32'sh7FFFFFFF;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words under the reset settings: centre, extremes, a few widths.
    dir_rows.push_back('{32'sd0, 1, 17'd65536, 1'b0});
    dir_rows.push_back('{32'sh7FFFFFFF, 1, 17'd0, 1'b0});
    dir_rows.push_back('{32'sh80000000, 1, 17'd0, 1'b0});
    dir_rows.push_back('{32'sd1, 0, 17'd0, 1'b0});
    dir_rows.push_back('{-32'sd1, 0, 17'd0, 1'b0});
    dir_rows.push_back('{32'sd65536, 0, 17'd0, 1'b0});
    dir_rows.push_back('{-32'sd65536, 0, 17'd0, 1'b0});
    dir_rows.push_back('{32'sd131072, 0, 17'd0, 1'b0});
    dir_rows.push_back('{32'sd262144, 0, 17'd0, 1'b0});
    dir_rows.push_back('{32'sd370727, 0, 17'd0, 1'b0});
    dir_rows.push_back('{32'sd370728, 0, 17'd0, 1'b0});
    dir_rows.push_back('{-32'sd370727, 0, 17'd0, 1'b0});
    dir_rows.push_back('{32'sd393216, 1, 17'd0, 1'b0});
    dir_rows.push_back('{32'sh55555555, 1, 17'd0, 1'b0});
    dir_rows.push_back('{32'shAAAAAAAA, 1, 17'd0, 1'b0});
    foreach (dir_rows[i])
      send_word(dir_rows[i].sample, dir_rows[i].known,
                '{dir_rows[i].density, dir_rows[i].outside});
    drain();

    // Narrow window set directly around a one-unit width; bounds are inside.
    load_setting(32'sd0, 31'd1, -32'sd3, 32'sd3);
    for (int v = -5; v <= 5; v++) send_word(v, 1'b0, '0);
    drain();

    // Empty window: everything is outside.
    load_setting(32'sd0, 31'd65536, 32'sd100, -32'sd100);
    send_word(32'sd0, 1'b1, '{17'd0, 1'b1});
    send_word(32'sd100, 1'b1, '{17'd0, 1'b1});
    send_word(-32'sd100, 1'b1, '{17'd0, 1'b1});
    drain();

    gaps_on = 1'b1;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: load_setting(32'sd0, 31'd1, 32'sh80000000, 32'sh7FFFFFFF);
        1: load_setting(32'sh7FFFFFFF, 31'h7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        2: load_setting(32'sh80000000, 31'd65536, -32'sd1000, 32'sd1000);
        3: load_setting(32'sd327680, 31'd65536, 32'sd327680, 32'sd327680);
        4: load_setting(32'sd0, 31'd65536, 32'sd70000, -32'sd70000);
        default: begin
          m = $urandom;
          w = 31'(($urandom & ((32'd1 << $urandom_range(0, 30)) - 1)) | 32'd1);
          a = clamp32(longint'(m) - longint'($urandom_range(0, 8)) * longint'(w));
          b = clamp32(longint'(m) + longint'($urandom_range(0, 8)) * longint'(w));
          load_setting(m, w, a, b);
        end
      endcase
      // The last settings run with no gaps at all.
      if (ph >= 8) gaps_on = 1'b0;
      random_words(ITEMS_PER_SETTING);
      drain();
    end

    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+design
design/tgd_pkg.sv
design/tgd_front.sv
design/tgd_divider.sv
design/tgd_exp_series.sv
design/truncated_gaussian_density.sv
design/tgd_checker.sv
tb/tb_top.sv
